// ----- rtl/heading_pid_with_settle_defines.svh -----
// Assertion helpers used by heading_pid_with_settle.sv. Each expects clk and rst in scope.
`ifndef HEADING_PID_WITH_SETTLE_DEFINES_SVH
`define HEADING_PID_WITH_SETTLE_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define HPS_ASSERT_HOLDS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define HPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hps_pkg.sv -----
`default_nettype none

package hps_pkg;

  localparam int INTEGRATOR_LIMIT = 100000;
  localparam int FULL_TURN        = 36000;
  localparam int HALF_TURN        = 18000;
  localparam int Q_ONE            = 65536;
  localparam int ROUND_HALF       = 32768;

  localparam int PROD_W = 50;   // 32 x 18 signed product
  localparam int SUM_W  = 51;   // sum of three products with headroom
  localparam int ACC_W  = 18;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN_DT,
    REG_DERIV_GAIN_PER_DT,
    REG_TARGET_HEADING,
    REG_SPEED_LIMIT,
    REG_SETTLE_TOLERANCE,
    REG_SETTLE_TICKS,
    REG_TICK_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain_dt;
    logic signed [31:0] deriv_gain_per_dt;
    logic [15:0]        target_heading;
    logic [13:0]        speed_limit;
    logic [14:0]        settle_tolerance;
    logic [7:0]         settle_ticks;
    logic [15:0]        tick_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    STEP_FETCH,
    STEP_WRAP,
    STEP_ERR,
    STEP_INTEG,
    STEP_MUL_I,
    STEP_MUL_D,
    STEP_SUB,
    STEP_CLAMP,
    STEP_SCALE,
    STEP_EMIT,
    STEP_EMIT_IDLE
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_WRAP,
    OP_ERR,
    OP_INTEG,
    OP_MUL_I,
    OP_MUL_D,
    OP_SUB,
    OP_CLAMP,
    OP_SCALE,
    OP_EMIT,
    OP_EMIT_IDLE
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NOACC,
    HOLD_OUTBUSY
  } hold_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_IDLE,
    JMP_ALWAYS
  } jump_t;

  typedef struct packed {
    op_t   op;
    hold_t hold;
    jump_t jump;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic signed [14:0] left;
  } dp_status_t;

  // Control store: one word per step.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '{op: OP_NOP, hold: HOLD_NONE, jump: JMP_NONE, target: STEP_FETCH};
    case (s)
      STEP_FETCH:     c = '{OP_FETCH,     HOLD_NOACC,   JMP_NONE,   STEP_FETCH};
      STEP_WRAP:      c = '{OP_WRAP,      HOLD_NONE,    JMP_IDLE,   STEP_EMIT_IDLE};
      STEP_ERR:       c = '{OP_ERR,       HOLD_NONE,    JMP_NONE,   STEP_FETCH};
      STEP_INTEG:     c = '{OP_INTEG,     HOLD_NONE,    JMP_NONE,   STEP_FETCH};
      STEP_MUL_I:     c = '{OP_MUL_I,     HOLD_NONE,    JMP_NONE,   STEP_FETCH};
      STEP_MUL_D:     c = '{OP_MUL_D,     HOLD_NONE,    JMP_NONE,   STEP_FETCH};
      STEP_SUB:       c = '{OP_SUB,       HOLD_NONE,    JMP_NONE,   STEP_FETCH};
      STEP_CLAMP:     c = '{OP_CLAMP,     HOLD_NONE,    JMP_NONE,   STEP_FETCH};
      STEP_SCALE:     c = '{OP_SCALE,     HOLD_NONE,    JMP_NONE,   STEP_FETCH};
      STEP_EMIT:      c = '{OP_EMIT,      HOLD_OUTBUSY, JMP_ALWAYS, STEP_FETCH};
      STEP_EMIT_IDLE: c = '{OP_EMIT_IDLE, HOLD_OUTBUSY, JMP_ALWAYS, STEP_FETCH};
      default:        c.jump = JMP_ALWAYS;
    endcase
    return c;
  endfunction

  // Reduce a raw centidegree value into (-18000, 18000].
  function automatic logic signed [15:0] wrap_abs(logic [15:0] v);
    logic [16:0]        r;
    logic signed [17:0] s;
    r = {1'b0, v};
    if (v >= 16'(FULL_TURN)) begin
      r = r - 17'(FULL_TURN);
    end
    s = signed'({1'b0, r});
    if (s > $signed(18'(HALF_TURN))) begin
      s = s - $signed(18'(FULL_TURN));
    end
    return s[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/heading_pid_with_settle.sv -----
`default_nettype none
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[31:0]
//  in       in         in_valid / in_ready    heading[15:0], start_req
//  out      out        out_valid / out_ready  left_speed, right_speed, finished
//
//  An active tick runs a 10-step control program from request accept to the next
//  accept, with the 32 x 18 multiplier used in four passes. An idle tick (turn
//  ended, no start) runs only the fetch, wrap and idle emit steps.
//  The next request is taken once the result sits in the output register;
//  a stalled output holds the program at its emit step.
//  Reset sets the config registers to their listed values, clears out_valid and marks the turn ended.

module heading_pid_with_settle import hps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        heading,
  input  logic               start_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] left_speed,
  output logic signed [14:0] right_speed,
  output logic               finished
);

`include "heading_pid_with_settle_defines.svh"

  cfg_t       cfg;
  step_t      pc;
  step_t      pc_next;
  ctrl_t      ctrl;
  dp_status_t status;
  logic [15:0] heading_q;
  logic        start_q;
  logic        in_fire;
  logic        emit_ok;
  logic        hold;
  logic        take;
  logic        emit_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain         <= '0;
      cfg.integ_gain_dt     <= '0;
      cfg.deriv_gain_per_dt <= '0;
      cfg.target_heading    <= '0;
      cfg.speed_limit       <= 14'd7000;
      cfg.settle_tolerance  <= 15'd100;
      cfg.settle_ticks      <= 8'd50;
      cfg.tick_limit        <= 16'd375;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:         cfg.prop_gain         <= cfg_data;
        REG_INTEG_GAIN_DT:     cfg.integ_gain_dt     <= cfg_data;
        REG_DERIV_GAIN_PER_DT: cfg.deriv_gain_per_dt <= cfg_data;
        REG_TARGET_HEADING:    cfg.target_heading    <= cfg_data[15:0];
        REG_SPEED_LIMIT:       cfg.speed_limit       <= cfg_data[13:0];
        REG_SETTLE_TOLERANCE:  cfg.settle_tolerance  <= cfg_data[14:0];
        REG_SETTLE_TICKS:      cfg.settle_ticks      <= cfg_data[7:0];
        REG_TICK_LIMIT:        cfg.tick_limit        <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: fetch the control word, then hold, jump or advance.
  assign ctrl     = ucode(pc);
  assign in_ready = (ctrl.hold == HOLD_NOACC);
  assign in_fire  = in_valid && in_ready;
  assign emit_ok  = !out_valid || out_ready;

  always_comb begin
    case (ctrl.hold)
      HOLD_NOACC:   hold = !in_fire;
      HOLD_OUTBUSY: hold = !emit_ok;
      default:      hold = 1'b0;
    endcase
    case (ctrl.jump)
      JMP_IDLE:   take = status.idle;
      JMP_ALWAYS: take = 1'b1;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_FETCH && in_fire) begin
      heading_q <= heading;
      start_q   <= start_req;
    end
  end

  hps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .heading_q (heading_q),
    .start_q   (start_q),
    .status    (status)
  );

  assign emit_fire = ((ctrl.op == OP_EMIT) || (ctrl.op == OP_EMIT_IDLE)) && emit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (ctrl.op == OP_EMIT) begin
        left_speed  <= status.left;
        right_speed <= -status.left;
        finished    <= status.done;
      end else begin
        left_speed  <= '0;
        right_speed <= '0;
        finished    <= 1'b1;
      end
    end
  end

  `HPS_ASSERT_HOLDS(a_right_mirrors_left, !out_valid || right_speed == -left_speed, "right speed is not the negated left speed")
  `HPS_ASSERT_NEXT(a_accept_starts_program, in_valid && in_ready, pc == STEP_WRAP, "program did not start after request accept")
  `HPS_ASSERT_NEXT(a_emit_waits, pc == STEP_EMIT && out_valid && !out_ready, pc == STEP_EMIT, "emit step left while output slot was full")

endmodule

`default_nettype wire

// ----- rtl/hps_datapath.sv -----
`default_nettype none

module hps_datapath import hps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_t        ctrl,
  input  cfg_t         cfg,
  input  logic [15:0]  heading_q,
  input  logic         start_q,
  output dp_status_t   status
);

  logic signed [15:0]        hw;
  logic signed [15:0]        tw;
  logic signed [15:0]        err;
  logic [15:0]               ad;
  logic signed [ACC_W-1:0]   acc;
  logic signed [15:0]        prev;
  logic signed [16:0]        diff;
  logic [7:0]                settle_cnt;
  logic [15:0]               elapsed;
  logic                      done_flag;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [17:0]        tot;
  logic                      neg;

  logic signed [16:0]        err_raw;
  logic signed [16:0]        err_wrapped;
  logic signed [16:0]        hw_diff;
  logic [15:0]               ad_next;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [31:0]        mul_a;
  logic signed [17:0]        mul_b;
  logic signed [PROD_W-1:0]  product;
  logic signed [17:0]        tot_next;
  logic [16:0]               mag;
  logic [30:0]               rnd;
  logic [14:0]               mag_out;
  logic                      on_target;

  always_comb begin
    err_raw = 17'(tw) - 17'(hw);
    err_wrapped = err_raw;
    if (err_raw > $signed(17'(HALF_TURN))) begin
      err_wrapped = err_raw - $signed(17'(FULL_TURN));
    end else if (err_raw <= -$signed(17'(HALF_TURN))) begin
      err_wrapped = err_raw + $signed(17'(FULL_TURN));
    end
    hw_diff = 17'(hw) - 17'(tw);
    ad_next = (hw_diff < 0) ? 16'(-hw_diff) : 16'(hw_diff);
  end

  always_comb begin
    acc_sum = (ACC_W + 1)'(acc) + (ACC_W + 1)'(err);
    if (acc_sum > $signed((ACC_W + 1)'(INTEGRATOR_LIMIT))) begin
      acc_next = ACC_W'(INTEGRATOR_LIMIT);
    end else if (acc_sum < -$signed((ACC_W + 1)'(INTEGRATOR_LIMIT))) begin
      acc_next = -$signed(ACC_W'(INTEGRATOR_LIMIT));
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
  end

  assign on_target = (ad <= {1'b0, cfg.settle_tolerance});

  // One shared multiplier; the control word picks its operands.
  always_comb begin
    mul_a = cfg.prop_gain;
    mul_b = 18'(err);
    case (ctrl.op)
      OP_MUL_I: begin
        mul_a = cfg.integ_gain_dt;
        mul_b = acc;
      end
      OP_MUL_D: begin
        mul_a = cfg.deriv_gain_per_dt;
        mul_b = 18'(diff);
      end
      OP_SCALE: begin
        mul_a = signed'({15'd0, mag});
        mul_b = signed'({4'd0, cfg.speed_limit});
      end
      default: begin
        mul_a = cfg.prop_gain;
        mul_b = 18'(err);
      end
    endcase
  end

  assign product = mul_a * mul_b;

  always_comb begin
    if (sum > $signed(SUM_W'(Q_ONE))) begin
      tot_next = 18'(Q_ONE);
    end else if (sum < -$signed(SUM_W'(Q_ONE))) begin
      tot_next = -$signed(18'(Q_ONE));
    end else begin
      tot_next = sum[17:0];
    end
  end

  assign mag = neg ? 17'(-tot) : 17'(tot);

  // Round half away from zero on the magnitude.
  assign rnd     = prod[30:0] + 31'(ROUND_HALF);
  assign mag_out = rnd[30:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      prev       <= '0;
      settle_cnt <= '0;
      elapsed    <= '0;
      done_flag  <= 1'b1;
    end else begin
      case (ctrl.op)
        OP_WRAP: begin
          hw <= wrap_abs(heading_q);
          tw <= wrap_abs(cfg.target_heading);
          if (start_q) begin
            acc        <= '0;
            prev       <= '0;
            settle_cnt <= '0;
            elapsed    <= '0;
            done_flag  <= 1'b0;
          end
        end
        OP_ERR: begin
          err <= err_wrapped[15:0];
          ad  <= ad_next;
        end
        OP_INTEG: begin
          acc  <= acc_next;
          diff <= 17'(err) - 17'(prev);
          prev <= err;
          prod <= product;
          if (elapsed != 16'hFFFF) begin
            elapsed <= elapsed + 16'd1;
          end
          if (on_target) begin
            if (settle_cnt != 8'hFF) begin
              settle_cnt <= settle_cnt + 8'd1;
            end
          end else begin
            settle_cnt <= '0;
          end
        end
        OP_MUL_I: begin
          sum       <= SUM_W'(prod);
          prod      <= product;
          done_flag <= (settle_cnt > cfg.settle_ticks) || (elapsed >= cfg.tick_limit);
        end
        OP_MUL_D: begin
          sum  <= sum + SUM_W'(prod);
          prod <= product;
        end
        OP_SUB: begin
          sum <= sum - SUM_W'(prod);
        end
        OP_CLAMP: begin
          tot <= tot_next;
          neg <= (sum < 0);
        end
        OP_SCALE: begin
          prod <= product;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.idle = done_flag & ~start_q;
  assign status.done = done_flag;
  assign status.left = neg ? -signed'(mag_out) : signed'(mag_out);

endmodule

`default_nettype wire
